FILE: rtl/preemptive_priority_scheduler_core_macros.svh
// Assertion macros for the preemptive priority scheduler.
// Used by the top level; they expect signals named clk and rst in scope.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_CORE_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PPS_ASSERT_CLK(label, prop) label: assert property (@(posedge clk) disable iff (rst) \
  prop) else $error("scheduler assertion failed");
`define PPS_ASSERT_NEVER(label, expr) label: assert property (@(posedge clk) disable iff (rst) \
  !(expr)) else $error("scheduler forbidden condition seen");
`else
`define PPS_ASSERT_CLK(label, prop)
`define PPS_ASSERT_NEVER(label, expr)
`endif
`endif

FILE: rtl/ppsched_pkg.sv
// Shared types and constants of the preemptive priority scheduler.
// Used by ppsched_cell and the top level; depends on nothing.
`default_nettype none
package ppsched_pkg;

  localparam int ACT_W   = 2;
  localparam int ID_W    = 4;
  localparam int BURST_W = 10;
  localparam int TIME_W  = 16;
  localparam int PRIO_W  = 8;

  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic               clear;
    logic               load;
    logic [ID_W-1:0]    load_id;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  arrival;
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  now;
    logic               grant;
  } ctl_t;

  // Running summary handed from one cell to the next.
  typedef struct packed {
    logic              elig;     // some eligible job seen so far
    logic [PRIO_W-1:0] prio;     // best candidate priority
    logic [TIME_W-1:0] arrival;  // best candidate arrival
    logic              any_big;  // some loaded slot with two or more ticks left
    logic [1:0]        n_one;    // loaded slots with one tick left, saturating at two
  } chain_t;

endpackage
`default_nettype wire

FILE: rtl/ppsched_cell.sv
// One job slot of the scheduler with its stage of the selection chain.
// Depends on ppsched_pkg for the control and chain types.
`default_nettype none
module ppsched_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 4
) (
  input  wire                  clk,
  input  wire                  rst,
  input  ppsched_pkg::ctl_t    ctl,
  input  wire [IDX_W-1:0]      grant_id,
  input  ppsched_pkg::chain_t  chain_in,
  input  wire [IDX_W-1:0]      id_in,
  output ppsched_pkg::chain_t  chain_out,
  output logic [IDX_W-1:0]     id_out
);

  logic                                valid;
  logic [ppsched_pkg::PRIO_W-1:0]      prio;
  logic [ppsched_pkg::TIME_W-1:0]      arrival;
  logic [ppsched_pkg::BURST_W-1:0]     remaining;

  logic                 elig_own;
  logic                 take;
  logic                 one_left;
  ppsched_pkg::chain_t  chain_next;
  logic [IDX_W-1:0]     id_next;

  always_comb begin
    elig_own = valid && (remaining != '0) && (arrival <= ctl.now);
    // Only a strictly better slot displaces the incoming candidate, so lower ids win ties.
    take = elig_own && (!chain_in.elig || (prio < chain_in.prio) ||
                        ((prio == chain_in.prio) && (arrival < chain_in.arrival)));
    one_left = valid && (remaining == ppsched_pkg::BURST_W'(1));
    chain_next = chain_in;
    id_next    = id_in;
    chain_next.elig    = chain_in.elig | elig_own;
    chain_next.any_big = chain_in.any_big | (valid && (remaining > ppsched_pkg::BURST_W'(1)));
    if (one_left && (chain_in.n_one != 2'd2)) begin
      chain_next.n_one = chain_in.n_one + 2'd1;
    end
    if (take) begin
      chain_next.prio    = prio;
      chain_next.arrival = arrival;
      id_next            = IDX_W'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      chain_out <= '0;
    end else begin
      chain_out <= chain_next;
      if (ctl.clear) begin
        valid <= 1'b0;
      end else if (ctl.load && (32'(ctl.load_id) == INDEX)) begin
        valid     <= 1'b1;
        remaining <= ctl.burst;
        arrival   <= ctl.arrival;
        prio      <= ctl.prio;
      end else if (ctl.grant && (grant_id == IDX_W'(INDEX))) begin
        remaining <= remaining - ppsched_pkg::BURST_W'(1);
      end
    end
    id_out <= id_next;
  end

endmodule
`default_nettype wire

FILE: rtl/preemptive_priority_scheduler_core.sv
// A request is accepted in ST_IDLE; the selection wave then crosses the whole row of
// slot cells, one cell per cycle, while the block sits in ST_SCAN, and the result is
// posted from ST_FINISH. A new request is taken only after the last result is posted.
// A result waiting on m_tready holds the block in its final state until taken.
// Synchronous active-high reset empties every slot, zeroes the time and drops m_tvalid.
// Depends on ppsched_pkg, ppsched_cell and the assertion macro header.
`default_nettype none
`include "preemptive_priority_scheduler_core_macros.svh"
module preemptive_priority_scheduler_core #(
  parameter int MAX_JOBS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [1:0]  s_tuser,   // action[1:0]
  input  wire  [39:0] s_tdata,   // job_id[3:0], burst[13:4], arrival[29:14],
                                 // prio[37:30], zero fill[39:38]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata    // granted_id[3:0], idle[4], all_done[5],
                                 // tick_time[21:6], zero fill[23:22]
);

  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS);

  // The controller accepts one request, applies clear or load at the accept edge,
  // then lets the selection wave run across the cells. Each cell compares its slot
  // against the best candidate from its left neighbor and registers the winner,
  // together with running counts used to judge whether all work is done.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                              state;
  logic [CNT_W-1:0]                    cnt;
  logic [ppsched_pkg::TIME_W-1:0]      now_time;
  logic [ppsched_pkg::TIME_W-1:0]      tick_time;
  logic                                is_tick;

  logic                 accept;
  logic                 out_free;
  logic                 finish;
  logic                 grant_fire;
  logic                 all_done;
  logic [ppsched_pkg::ACT_W-1:0] in_action;
  ppsched_pkg::ctl_t    ctl;
  ppsched_pkg::chain_t  chain [MAX_JOBS];
  logic [IDX_W-1:0]     cid   [MAX_JOBS];
  ppsched_pkg::chain_t  winner;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign in_action = s_tuser;
  assign out_free  = !m_tvalid || m_tready;
  assign finish    = (state == ST_FINISH) && out_free;
  assign winner    = chain[MAX_JOBS-1];

  // A grant happens only for a tick that found an eligible slot.
  assign grant_fire = is_tick && winner.elig;

  // All done after this request: no slot with two or more ticks left, and at most
  // one slot with a single tick left, which must be the one served right now.
  assign all_done = !winner.any_big &&
                    ((winner.n_one == 2'd0) || ((winner.n_one == 2'd1) && grant_fire));

  always_comb begin
    ctl         = '0;
    ctl.clear   = accept && (in_action == ppsched_pkg::ACT_CLEAR);
    ctl.load    = accept && (in_action == ppsched_pkg::ACT_LOAD);
    ctl.load_id = s_tdata[3:0];
    ctl.burst   = s_tdata[13:4];
    ctl.arrival = s_tdata[29:14];
    ctl.prio    = s_tdata[37:30];
    ctl.now     = now_time;
    ctl.grant   = finish && grant_fire;
  end

  genvar g;
  generate
    for (g = 0; g < MAX_JOBS; g++) begin : g_cell
      ppsched_pkg::chain_t  link_in;
      logic [IDX_W-1:0]     link_id;
      if (g == 0) begin : g_head
        assign link_in = '0;
        assign link_id = '0;
      end else begin : g_body
        assign link_in = chain[g-1];
        assign link_id = cid[g-1];
      end
      ppsched_cell #(
        .INDEX (g),
        .IDX_W (IDX_W)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .grant_id  (cid[MAX_JOBS-1]),
        .chain_in  (link_in),
        .id_in     (link_id),
        .chain_out (chain[g]),
        .id_out    (cid[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      now_time <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // A result taken in the same cycle as a new one is posted stays valid.
      if (m_tvalid && m_tready && !finish) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            tick_time <= now_time;
            is_tick   <= (in_action == ppsched_pkg::ACT_TICK);
            if (in_action == ppsched_pkg::ACT_CLEAR) begin
              now_time <= '0;
            end
            cnt   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt == CNT_W'(MAX_JOBS - 1)) begin
            state <= ST_FINISH;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, tick_time, all_done, !grant_fire,
                         grant_fire ? ppsched_pkg::ID_W'(cid[MAX_JOBS-1])
                                    : ppsched_pkg::ID_W'(0)};
            if (is_tick && (now_time != '1)) begin
              now_time <= now_time + ppsched_pkg::TIME_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `PPS_ASSERT_CLK(a_accept_starts_scan, accept |=> (state == ST_SCAN))
  `PPS_ASSERT_CLK(a_finish_gives_result, finish |=> m_tvalid)
  `PPS_ASSERT_CLK(a_tick, (finish && is_tick) |=> (&now_time || now_time == $past(now_time) + 1'b1))
  `PPS_ASSERT_NEVER(a_grant_outside_finish, ctl.grant && (state != ST_FINISH))

endmodule
`default_nettype wire
